// File: hdl/window_pixel_clip_alpha_blend_defines.svh
// Assertion macros for the window pixel compositor.
// Expects clk and rst_n in the scope of each use.
`ifndef WINDOW_PIXEL_CLIP_ALPHA_BLEND_DEFINES_SVH
`define WINDOW_PIXEL_CLIP_ALPHA_BLEND_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only out of reset
`define WPCAB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("wpcab assertion failed");

// Checked on every edge, reset included
`define WPCAB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wpcab assertion failed");

`else

`define WPCAB_ASSERT(lbl, prop)
`define WPCAB_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: hdl/wpcab_pkg.sv
// Package for the window pixel compositor: payload types, register map,
// clip test and ARGB8888 source-over functions. No dependencies.
`timescale 1ns / 1ps

package wpcab_pkg;

  localparam int PADDR_W = 5;
  localparam int REG_W   = 13;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_WINDOW_LEFT    = 3'd0;
  localparam reg_idx_t REG_WINDOW_TOP     = 3'd1;
  localparam reg_idx_t REG_WINDOW_WIDTH   = 3'd2;
  localparam reg_idx_t REG_WINDOW_HEIGHT  = 3'd3;
  localparam reg_idx_t REG_TEXTURE_WIDTH  = 3'd4;
  localparam reg_idx_t REG_TEXTURE_HEIGHT = 3'd5;
  localparam reg_idx_t REG_SCREEN_WIDTH   = 3'd6;
  localparam reg_idx_t REG_SCREEN_HEIGHT  = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic [31:0] dest_pixel;
    logic [31:0] source_pixel;
    logic        force_blend;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] out_pixel;
  } out_item_t;

  // Inside clipped window span and texture along one axis
  function automatic logic axis_inside(input logic [11:0]       pos,
                                       input logic [REG_W-1:0]  win_edge,
                                       input logic [REG_W-1:0]  win_size,
                                       input logic [REG_W-1:0]  scr_size,
                                       input logic [REG_W-1:0]  tex_size);
    logic signed [14:0] p;
    logic signed [14:0] e;
    logic signed [14:0] hi;
    logic signed [14:0] off;
    p   = $signed({3'b000, pos});
    e   = $signed({{2{win_edge[REG_W-1]}}, win_edge});
    hi  = e + $signed({2'b00, win_size});
    off = p - e;
    return (p >= e) && (p < hi) && (p < $signed({2'b00, scr_size})) &&
           (off < $signed({2'b00, tex_size}));
  endfunction

  // Truncating divide by 255, exact for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [31:0] source_over(input logic [31:0] dst,
                                              input logic [31:0] src);
    logic [7:0]  sa;
    logic [7:0]  inv;
    logic [15:0] acc;
    logic [31:0] res;
    sa  = src[31:24];
    inv = ALPHA_OPAQUE - sa;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      acc = 16'(src[8*c +: 8]) * 16'(sa) + 16'(dst[8*c +: 8]) * 16'(inv);
      res[8*c +: 8] = div255(acc);
    end
    res[31:24] = sa + div255(16'(dst[31:24]) * 16'(inv));
    if (sa == ALPHA_CLEAR) begin
      res = dst;
    end else if (sa == ALPHA_OPAQUE) begin
      res = src;
    end
    return res;
  endfunction

endpackage

// File: hdl/window_pixel_clip_alpha_blend.sv
// Window pixel compositor top level: register file, clip test and blend.
// Depends on wpcab_pkg and window_pixel_clip_alpha_blend_defines.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one screen pixel per
//   transaction: position, framebuffer pixel, window pixel, force-blend.
//   Output channel out_valid/out_ready/out_data returns one transaction per
//   input: write_enable and the new framebuffer pixel (the old one when
//   write_enable is low).
//   An input register, then the clip test and blend into the result
//   register. One transaction per cycle is sustained while the receiver
//   is ready. When the receiver stalls, the result register holds and the
//   input register takes one more transaction if empty, then in_ready drops.
//   Window, texture and screen geometry are written over the APB port at
//   byte address 4*i; writes are expected only while the block is empty.
//   Reset empties both stages and loads the register reset values
//   (window size 1x1, all other geometry 0).
`timescale 1ns / 1ps
`include "window_pixel_clip_alpha_blend_defines.svh"

module window_pixel_clip_alpha_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wpcab_pkg::in_item_t           in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wpcab_pkg::out_item_t          out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpcab_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wpcab_pkg::*;

  logic [REG_W-1:0] window_left_r;
  logic [REG_W-1:0] window_top_r;
  logic [REG_W-1:0] window_width_r;
  logic [REG_W-1:0] window_height_r;
  logic [REG_W-1:0] texture_width_r;
  logic [REG_W-1:0] texture_height_r;
  logic [REG_W-1:0] screen_width_r;
  logic [REG_W-1:0] screen_height_r;

  reg_idx_t         reg_idx;
  logic             reg_wr;
  logic [REG_W-1:0] rd_val;

  in_item_t  s1_r;
  logic      s1_vld_r;
  logic      s1_vld_nxt;
  out_item_t res_r;
  out_item_t res_nxt;
  logic      res_vld_r;
  logic      res_vld_nxt;

  logic in_fire;
  logic res_take;
  logic s1_adv;
  logic hit;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_left_r    <= '0;
      window_top_r     <= '0;
      window_width_r   <= REG_W'(1);
      window_height_r  <= REG_W'(1);
      texture_width_r  <= '0;
      texture_height_r <= '0;
      screen_width_r   <= '0;
      screen_height_r  <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_WINDOW_LEFT:    window_left_r    <= pwdata[REG_W-1:0];
        REG_WINDOW_TOP:     window_top_r     <= pwdata[REG_W-1:0];
        REG_WINDOW_WIDTH:   window_width_r   <= pwdata[REG_W-1:0];
        REG_WINDOW_HEIGHT:  window_height_r  <= pwdata[REG_W-1:0];
        REG_TEXTURE_WIDTH:  texture_width_r  <= pwdata[REG_W-1:0];
        REG_TEXTURE_HEIGHT: texture_height_r <= pwdata[REG_W-1:0];
        REG_SCREEN_WIDTH:   screen_width_r   <= pwdata[REG_W-1:0];
        REG_SCREEN_HEIGHT:  screen_height_r  <= pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LEFT:    rd_val = window_left_r;
      REG_WINDOW_TOP:     rd_val = window_top_r;
      REG_WINDOW_WIDTH:   rd_val = window_width_r;
      REG_WINDOW_HEIGHT:  rd_val = window_height_r;
      REG_TEXTURE_WIDTH:  rd_val = texture_width_r;
      REG_TEXTURE_HEIGHT: rd_val = texture_height_r;
      REG_SCREEN_WIDTH:   rd_val = screen_width_r;
      REG_SCREEN_HEIGHT:  rd_val = screen_height_r;
    endcase
  end

  assign prdata = {{(32-REG_W){1'b0}}, rd_val};

  // Two-stage pipeline control
  assign res_take    = !res_vld_r || out_ready;
  assign s1_adv      = s1_vld_r && res_take;
  assign in_ready    = !s1_vld_r || res_take;
  assign in_fire     = in_valid && in_ready;
  assign s1_vld_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
  assign res_vld_nxt = res_take ? s1_vld_r : res_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  // Clip test and blend
  assign hit = axis_inside(s1_r.screen_x, window_left_r, window_width_r,
                           screen_width_r, texture_width_r) &&
               axis_inside(s1_r.screen_y, window_top_r, window_height_r,
                           screen_height_r, texture_height_r);

  always_comb begin
    res_nxt.write_enable = hit;
    res_nxt.out_pixel    = s1_r.dest_pixel;
    if (hit) begin
      if (!s1_r.force_blend && (s1_r.source_pixel[31:24] == ALPHA_OPAQUE)) begin
        res_nxt.out_pixel = s1_r.source_pixel;
      end else begin
        res_nxt.out_pixel = source_over(s1_r.dest_pixel, s1_r.source_pixel);
      end
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  `WPCAB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid && in_ready))
  `WPCAB_ASSERT(a_stall_full, !in_ready |-> (s1_vld_r && res_vld_r))
  `WPCAB_ASSERT(a_miss_passes, (s1_adv && !hit) |=> (out_valid && !out_data.write_enable && out_data.out_pixel == $past(s1_r.dest_pixel)))
  `WPCAB_ASSERT(a_opaque_copy, (s1_adv && hit && !s1_r.force_blend && s1_r.source_pixel[31:24] == ALPHA_OPAQUE) |=> (out_data.out_pixel == $past(s1_r.source_pixel)))

endmodule
